// ===== src/mkrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mkrs_pkg
// Shared types, constants and helpers for the message keyword risk scanner.
// ----------------------------------------------------------------------------
package mkrs_pkg;

	localparam int unsigned MAX_LEN_DEF = 1024;
	localparam int unsigned CNT_W       = 11;
	localparam int unsigned CNT_LIMIT   = 2047;
	localparam int unsigned KW_W        = 9;
	localparam int unsigned KWT_W       = 10;
	localparam int unsigned SCORE_W     = 16;
	localparam int unsigned RISK_W      = 2;
	localparam int unsigned WEIGHT_W    = 6;
	localparam int unsigned CFG_IDX_W   = 8;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned HIST_DEPTH  = 4;

	localparam logic [KW_W-1:0] KW_CAP = KW_W'(256);

	localparam logic [WEIGHT_W-1:0] SPECIAL_WEIGHT_RST = WEIGHT_W'(2);
	localparam logic [WEIGHT_W-1:0] KEYWORD_WEIGHT_RST = WEIGHT_W'(15);
	localparam logic [SCORE_W-1:0]  HIGH_THRESH_RST    = SCORE_W'(50);
	localparam logic [SCORE_W-1:0]  MED_THRESH_RST     = SCORE_W'(20);

	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] FOLD_OFS   = 8'h20;
	localparam logic [7:0] CH_A       = 8'h61;
	localparam logic [7:0] CH_C       = 8'h63;
	localparam logic [7:0] CH_D       = 8'h64;
	localparam logic [7:0] CH_H       = 8'h68;
	localparam logic [7:0] CH_I       = 8'h69;
	localparam logic [7:0] CH_K       = 8'h6B;
	localparam logic [7:0] CH_M       = 8'h6D;
	localparam logic [7:0] CH_N       = 8'h6E;
	localparam logic [7:0] CH_O       = 8'h6F;
	localparam logic [7:0] CH_R       = 8'h72;
	localparam logic [7:0] CH_T       = 8'h74;

	typedef enum logic [RISK_W-1:0] {
		RISK_LOW  = 2'd0,
		RISK_MED  = 2'd1,
		RISK_HIGH = 2'd2
	} risk_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPECIAL_WEIGHT = 8'd0,
		REG_KEYWORD_WEIGHT = 8'd1,
		REG_HIGH_THRESH    = 8'd2,
		REG_MED_THRESH     = 8'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_char;
	} in_t;

	typedef struct packed {
		logic [CNT_W-1:0]   msg_length;
		logic [CNT_W-1:0]   special_count;
		logic [CNT_W-1:0]   digit_count;
		logic [CNT_W-1:0]   space_count;
		logic [CNT_W-1:0]   upper_count;
		logic [KW_W-1:0]    hack_count;
		logic [KW_W-1:0]    root_count;
		logic [KW_W-1:0]    admin_count;
		logic [KWT_W-1:0]   keyword_total;
		logic [SCORE_W-1:0] suspicion_score;
		logic [RISK_W-1:0]  risk_level;
	} out_t;

	typedef struct packed {
		logic [CNT_W-1:0] msg_length;
		logic [CNT_W-1:0] special_count;
		logic [CNT_W-1:0] digit_count;
		logic [CNT_W-1:0] space_count;
		logic [CNT_W-1:0] upper_count;
		logic [KW_W-1:0]  hack_count;
		logic [KW_W-1:0]  root_count;
		logic [KW_W-1:0]  admin_count;
	} counts_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] special_weight;
		logic [WEIGHT_W-1:0] keyword_weight;
		logic [SCORE_W-1:0]  high_risk_threshold;
		logic [SCORE_W-1:0]  medium_risk_threshold;
	} cfg_t;

	function automatic logic [7:0] fold(input logic [7:0] b);
		return (b >= CH_UP_A && b <= CH_UP_Z) ? b + FOLD_OFS : b;
	endfunction

	function automatic logic is_special(input logic [7:0] b);
		return b == CH_AT || b == CH_HASH || b == CH_PERCENT || b == CH_AMP ||
			b == CH_STAR || b == CH_BANG || b == CH_QUEST;
	endfunction

endpackage

// ===== src/message_keyword_risk_scanner.sv =====
// ----------------------------------------------------------------------------
// message_keyword_risk_scanner
// Streaming message scanner: class counts, keyword hits, score and risk level.
// ----------------------------------------------------------------------------
// Takes one message byte per clock, with last_char on the final byte, except
// while a final byte waits on a full report register; the counter and history
// update is combinational and registered. A message's report passes
// through the input, report and result registers to out_data, and bytes of
// the next message keep flowing while a report waits. Class counts saturate
// at min(MAX_LEN, 2047), keyword counts at 256 and the score at 65535.
// Configuration writes go through cfg_index/cfg_data and are to be issued
// only while no message is in flight; unknown indexes are dropped.
module message_keyword_risk_scanner #(
	parameter int unsigned MAX_LEN = mkrs_pkg::MAX_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  mkrs_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output mkrs_pkg::out_t                      out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mkrs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mkrs_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mkrs_pkg::*;

	localparam int unsigned CNT_CAP = (MAX_LEN < CNT_LIMIT) ? MAX_LEN : CNT_LIMIT;

	cfg_t    cfg_q;
	logic    rpt_valid;
	logic    rpt_ready;
	counts_t rpt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.special_weight        <= SPECIAL_WEIGHT_RST;
			cfg_q.keyword_weight        <= KEYWORD_WEIGHT_RST;
			cfg_q.high_risk_threshold   <= HIGH_THRESH_RST;
			cfg_q.medium_risk_threshold <= MED_THRESH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SPECIAL_WEIGHT: cfg_q.special_weight        <= cfg_data[WEIGHT_W-1:0];
				REG_KEYWORD_WEIGHT: cfg_q.keyword_weight        <= cfg_data[WEIGHT_W-1:0];
				REG_HIGH_THRESH:    cfg_q.high_risk_threshold   <= cfg_data[SCORE_W-1:0];
				REG_MED_THRESH:     cfg_q.medium_risk_threshold <= cfg_data[SCORE_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	mkrs_count #(
		.CNT_CAP (CNT_CAP)
	) u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.rpt       (rpt)
	);

	mkrs_score u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.rpt       (rpt),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== src/mkrs_count.sv =====
// ----------------------------------------------------------------------------
// mkrs_count
// Input register, per-message class and keyword counters, and report register.
// ----------------------------------------------------------------------------
module mkrs_count #(
	parameter int unsigned CNT_CAP = mkrs_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mkrs_pkg::in_t     in_data,
	output logic              rpt_valid,
	input  logic              rpt_ready,
	output mkrs_pkg::counts_t rpt
);
	import mkrs_pkg::*;

	localparam logic [CNT_W-1:0] CAP     = CNT_W'(CNT_CAP);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [KW_W-1:0]  KW_ONE  = KW_W'(1);

	logic             s1_valid_q;
	in_t              s1_q;
	logic [7:0]       hist_q [HIST_DEPTH];
	counts_t          cnt_q;
	counts_t          cnt_d;
	logic             rpt_valid_q;
	counts_t          rpt_q;
	logic             s1_move;
	logic [7:0]       c0;
	logic             hack_hit;
	logic             root_hit;
	logic             admin_hit;

	assign s1_move  = s1_valid_q && (!s1_q.last_char || !rpt_valid_q || rpt_ready);
	assign in_ready = !s1_valid_q || s1_move;

	always_comb begin
		c0        = fold(s1_q.char_byte);
		hack_hit  = hist_q[2] == CH_H && hist_q[1] == CH_A && hist_q[0] == CH_C && c0 == CH_K;
		root_hit  = hist_q[2] == CH_R && hist_q[1] == CH_O && hist_q[0] == CH_O && c0 == CH_T;
		admin_hit = hist_q[3] == CH_A && hist_q[2] == CH_D && hist_q[1] == CH_M &&
			hist_q[0] == CH_I && c0 == CH_N;
		cnt_d = cnt_q;
		cnt_d.msg_length = (cnt_q.msg_length < CAP) ? cnt_q.msg_length + CNT_ONE : CAP;
		priority if (is_special(s1_q.char_byte)) begin
			cnt_d.special_count = (cnt_q.special_count < CAP) ?
				cnt_q.special_count + CNT_ONE : CAP;
		end else if (s1_q.char_byte >= CH_0 && s1_q.char_byte <= CH_9) begin
			cnt_d.digit_count = (cnt_q.digit_count < CAP) ? cnt_q.digit_count + CNT_ONE : CAP;
		end else if (s1_q.char_byte == CH_SPACE) begin
			cnt_d.space_count = (cnt_q.space_count < CAP) ? cnt_q.space_count + CNT_ONE : CAP;
		end else if (s1_q.char_byte >= CH_UP_A && s1_q.char_byte <= CH_UP_Z) begin
			cnt_d.upper_count = (cnt_q.upper_count < CAP) ? cnt_q.upper_count + CNT_ONE : CAP;
		end else begin
			cnt_d.upper_count = cnt_q.upper_count;
		end
		if (hack_hit) begin
			cnt_d.hack_count = (cnt_q.hack_count < KW_CAP) ? cnt_q.hack_count + KW_ONE : KW_CAP;
		end
		if (root_hit) begin
			cnt_d.root_count = (cnt_q.root_count < KW_CAP) ? cnt_q.root_count + KW_ONE : KW_CAP;
		end
		if (admin_hit) begin
			cnt_d.admin_count = (cnt_q.admin_count < KW_CAP) ?
				cnt_q.admin_count + KW_ONE : KW_CAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s1_q <= in_data;
		end
	end

	// counters and history clear after each report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (s1_move) begin
			if (s1_q.last_char) begin
				cnt_q <= '0;
				for (int i = 0; i < HIST_DEPTH; i++) begin
					hist_q[i] <= '0;
				end
			end else begin
				cnt_q     <= cnt_d;
				hist_q[0] <= c0;
				for (int i = 1; i < HIST_DEPTH; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (s1_move && s1_q.last_char) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt_ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && s1_q.last_char) begin
			rpt_q <= cnt_d;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

	a_clear_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && s1_q.last_char |=> cnt_q == '0 && hist_q[0] == '0)
		else $error("counters not cleared after report");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q.msg_length <= CAP && cnt_q.hack_count <= KW_CAP)
		else $error("counter above cap");

	a_class_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q.special_count <= cnt_q.msg_length && cnt_q.digit_count <= cnt_q.msg_length &&
		cnt_q.space_count <= cnt_q.msg_length && cnt_q.upper_count <= cnt_q.msg_length)
		else $error("class count exceeds length");

	a_report_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid_q |-> rpt_q.msg_length != '0)
		else $error("report with empty message");

endmodule

// ===== src/mkrs_score.sv =====
// ----------------------------------------------------------------------------
// mkrs_score
// Keyword total, weighted suspicion score, risk level and result register.
// ----------------------------------------------------------------------------
module mkrs_score (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rpt_valid,
	output logic              rpt_ready,
	input  mkrs_pkg::counts_t rpt,
	input  mkrs_pkg::cfg_t    cfg,
	output logic              out_valid,
	input  logic              out_ready,
	output mkrs_pkg::out_t    out_data
);
	import mkrs_pkg::*;

	localparam int unsigned SP_W  = WEIGHT_W + CNT_W;
	localparam int unsigned KP_W  = WEIGHT_W + KWT_W;
	localparam int unsigned SUM_W = SP_W + 2;
	localparam logic [SUM_W-1:0] SCORE_MAX = SUM_W'({SCORE_W{1'b1}});

	logic [KWT_W-1:0]   kwt;
	logic [SP_W-1:0]    sp_prod;
	logic [KP_W-1:0]    kw_prod;
	logic [SUM_W-1:0]   sum;
	logic [SCORE_W-1:0] score;
	risk_t              risk;
	logic               out_valid_q;
	out_t               out_q;

	assign rpt_ready = !out_valid_q || out_ready;

	always_comb begin
		kwt     = KWT_W'(rpt.hack_count) + KWT_W'(rpt.root_count) + KWT_W'(rpt.admin_count);
		sp_prod = SP_W'(cfg.special_weight) * SP_W'(rpt.special_count);
		kw_prod = KP_W'(cfg.keyword_weight) * KP_W'(kwt);
		sum     = SUM_W'(sp_prod) + SUM_W'(kw_prod) + SUM_W'(rpt.digit_count) +
			SUM_W'(rpt.upper_count);
		score   = (sum > SCORE_MAX) ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
		priority if (score >= cfg.high_risk_threshold) begin
			risk = RISK_HIGH;
		end else if (score >= cfg.medium_risk_threshold) begin
			risk = RISK_MED;
		end else begin
			risk = RISK_LOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rpt_valid && rpt_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_valid && rpt_ready) begin
			out_q.msg_length      <= rpt.msg_length;
			out_q.special_count   <= rpt.special_count;
			out_q.digit_count     <= rpt.digit_count;
			out_q.space_count     <= rpt.space_count;
			out_q.upper_count     <= rpt.upper_count;
			out_q.hack_count      <= rpt.hack_count;
			out_q.root_count      <= rpt.root_count;
			out_q.admin_count     <= rpt.admin_count;
			out_q.keyword_total   <= kwt;
			out_q.suspicion_score <= score;
			out_q.risk_level      <= risk;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_kw_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.keyword_total == KWT_W'(out_q.hack_count) +
			KWT_W'(out_q.root_count) + KWT_W'(out_q.admin_count))
		else $error("keyword total mismatch");

	a_high_risk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.risk_level == RISK_HIGH |->
			out_q.suspicion_score >= cfg.high_risk_threshold)
		else $error("high risk below threshold");

	a_low_risk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.risk_level == RISK_LOW |->
			out_q.suspicion_score < cfg.medium_risk_threshold &&
			out_q.suspicion_score < cfg.high_risk_threshold)
		else $error("low risk at or above threshold");

endmodule

// ===== dv/risk_report_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// risk_report_checker
// Watches the byte, report and register channels of the scanner, keeps its
// own copy of the counters, history and registers, predicts the report of
// each message on its last byte and compares every report beat field by field.
// ----------------------------------------------------------------------------
module risk_report_checker
	import mkrs_pkg::*;
#(
	parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_t                   in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_t                  out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    reports_pending
);

	localparam int unsigned COUNT_CAP = (MAX_LEN < 2047) ? MAX_LEN : 2047;
	localparam int unsigned HIT_CAP   = 256;
	localparam longint unsigned SCORE_MAX = 65535;

	logic [WEIGHT_W-1:0] sp_weight, kw_weight;
	logic [SCORE_W-1:0]  high_thr, med_thr;
	logic [7:0]          history [HIST_DEPTH];
	int unsigned         n_len, n_special, n_digit, n_space, n_upper;
	int unsigned         n_hack, n_root, n_admin;
	out_t                reports_due [$];
	out_t                want;
	int                  errors = 0;

	assign mismatches = errors;

	function automatic logic [7:0] lower(input logic [7:0] b);
		return (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
	endfunction

	function automatic int unsigned sat_inc(input int unsigned v, input int unsigned cap);
		return (v < cap) ? v + 1 : cap;
	endfunction

	function automatic void clear_msg();
		foreach (history[i])
			history[i] = '0;
		n_len = 0;
		n_special = 0;
		n_digit = 0;
		n_space = 0;
		n_upper = 0;
		n_hack = 0;
		n_root = 0;
		n_admin = 0;
	endfunction

	function automatic void scan_char(input in_t beat);
		logic [7:0]      b, c0, p1, p2, p3, p4;
		out_t            rep;
		int unsigned     total;
		longint unsigned score;
		b = beat.char_byte;
		c0 = lower(b);
		p1 = lower(history[0]);
		p2 = lower(history[1]);
		p3 = lower(history[2]);
		p4 = lower(history[3]);
		n_len = sat_inc(n_len, COUNT_CAP);
		if (b == "@" || b == "#" || b == "%" || b == "&" || b == "*" || b == "!" || b == "?")
			n_special = sat_inc(n_special, COUNT_CAP);
		else if (b >= "0" && b <= "9")
			n_digit = sat_inc(n_digit, COUNT_CAP);
		else if (b == " ")
			n_space = sat_inc(n_space, COUNT_CAP);
		else if (b >= "A" && b <= "Z")
			n_upper = sat_inc(n_upper, COUNT_CAP);
		if (p3 == "h" && p2 == "a" && p1 == "c" && c0 == "k")
			n_hack = sat_inc(n_hack, HIT_CAP);
		if (p3 == "r" && p2 == "o" && p1 == "o" && c0 == "t")
			n_root = sat_inc(n_root, HIT_CAP);
		if (p4 == "a" && p3 == "d" && p2 == "m" && p1 == "i" && c0 == "n")
			n_admin = sat_inc(n_admin, HIT_CAP);
		history[3] = history[2];
		history[2] = history[1];
		history[1] = history[0];
		history[0] = b;
		if (beat.last_char) begin
			total = n_hack + n_root + n_admin;
			score = 64'(n_special) * sp_weight + n_digit + n_upper + 64'(total) * kw_weight;
			if (score > SCORE_MAX)
				score = SCORE_MAX;
			rep.msg_length = CNT_W'(n_len);
			rep.special_count = CNT_W'(n_special);
			rep.digit_count = CNT_W'(n_digit);
			rep.space_count = CNT_W'(n_space);
			rep.upper_count = CNT_W'(n_upper);
			rep.hack_count = KW_W'(n_hack);
			rep.root_count = KW_W'(n_root);
			rep.admin_count = KW_W'(n_admin);
			rep.keyword_total = KWT_W'(total);
			rep.suspicion_score = SCORE_W'(score);
			if (score >= high_thr)
				rep.risk_level = RISK_HIGH;
			else if (score >= med_thr)
				rep.risk_level = RISK_MED;
			else
				rep.risk_level = RISK_LOW;
			reports_due.push_back(rep);
			clear_msg();
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			errors++;
			if (errors <= 10)
				$display("%0t: report %s mismatch, expected %0d, got %0d",
					$time, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_weight = SPECIAL_WEIGHT_RST;
			kw_weight = KEYWORD_WEIGHT_RST;
			high_thr = HIGH_THRESH_RST;
			med_thr = MED_THRESH_RST;
			clear_msg();
			reports_due.delete();
			reports_pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: report beat with none outstanding, got %p",
							$time, out_data);
				end else begin
					want = reports_due.pop_front();
					check_field("msg_length", want.msg_length, out_data.msg_length);
					check_field("special_count", want.special_count, out_data.special_count);
					check_field("digit_count", want.digit_count, out_data.digit_count);
					check_field("space_count", want.space_count, out_data.space_count);
					check_field("upper_count", want.upper_count, out_data.upper_count);
					check_field("hack_count", want.hack_count, out_data.hack_count);
					check_field("root_count", want.root_count, out_data.root_count);
					check_field("admin_count", want.admin_count, out_data.admin_count);
					check_field("keyword_total", want.keyword_total, out_data.keyword_total);
					check_field("suspicion_score", want.suspicion_score,
						out_data.suspicion_score);
					check_field("risk_level", want.risk_level, out_data.risk_level);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SPECIAL_WEIGHT: sp_weight = cfg_data[WEIGHT_W-1:0];
					REG_KEYWORD_WEIGHT: kw_weight = cfg_data[WEIGHT_W-1:0];
					REG_HIGH_THRESH:    high_thr = cfg_data;
					REG_MED_THRESH:     med_thr = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				scan_char(in_data);
			reports_pending <= reports_due.size();
		end
	end

endmodule

// ===== dv/tb_message_keyword_risk_scanner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_message_keyword_risk_scanner
// Drives messages into the scanner byte by byte: a short directed set, one
// long message that pushes the length, upper-case and hack counters and the
// score into saturation, then random messages under a series of register
// settings, with random gaps on the byte side and random stalls on the report
// side. The checker predicts and compares; this module makes stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_message_keyword_risk_scanner;
	import mkrs_pkg::*;

	localparam int unsigned MAX_LEN = MAX_LEN_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_BYTES = 15;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_t                  out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int         fail_total;
	int         pending;
	int         idle_pct;
	int         stall_pct;
	int         cycle_count = 0;
	logic [7:0] msg_bytes [$];
	string      keywords [3] = '{"hack", "root", "admin"};
	string      specials = "@#%&*!?";

	message_keyword_risk_scanner #(.MAX_LEN(MAX_LEN)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	risk_report_checker #(.MAX_LEN(MAX_LEN)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (fail_total),
		.reports_pending (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// report-side stalls
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic last);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{char_byte: b, last_char: last};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_text(input string s, input logic close);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], close && (i == s.len() - 1));
	endtask

	task automatic send_msg();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
		msg_bytes.delete();
	endtask

	// sender holds off until every report is back and the pipe has emptied
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] sw, input logic [15:0] kw,
			input logic [15:0] hi, input logic [15:0] med, input logic poke_unmapped);
		if (poke_unmapped)
			write_reg(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
		write_reg(REG_SPECIAL_WEIGHT, sw);
		write_reg(REG_KEYWORD_WEIGHT, kw);
		write_reg(REG_HIGH_THRESH, hi);
		write_reg(REG_MED_THRESH, med);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] mixed_case(input logic [7:0] c);
		return $urandom_range(0, 1) ? (c & 8'hDF) : c;
	endfunction

	// mostly keywords and classed characters, some broken keywords and raw bytes
	task automatic build_message(input int len);
		int    pick;
		int    cut;
		string kw;
		while (msg_bytes.size() < len) begin
			pick = $urandom_range(0, 11);
			kw = keywords[$urandom_range(0, 2)];
			case (pick)
				0, 1, 2: begin
					for (int j = 0; j < kw.len(); j++)
						msg_bytes.push_back(mixed_case(kw[j]));
				end
				3: begin
					cut = $urandom_range(1, kw.len() - 1);
					for (int j = 0; j < cut; j++)
						msg_bytes.push_back(mixed_case(kw[j]));
				end
				4: msg_bytes.push_back(specials[$urandom_range(0, 6)]);
				5: msg_bytes.push_back(8'("0" + $urandom_range(0, 9)));
				6: msg_bytes.push_back(" ");
				7: msg_bytes.push_back(8'("A" + $urandom_range(0, 25)));
				8: msg_bytes.push_back(8'("a" + $urandom_range(0, 25)));
				default: msg_bytes.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		while (msg_bytes.size() > len)
			void'(msg_bytes.pop_back());
	endtask

	initial begin
		int sent;
		int len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 20;
		stall_pct = 20;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keyword cut by a message boundary, every class, odd bytes, all keywords
		send_text("hac", 1'b1);
		send_text("k@#%&*!?09 AZ", 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h0A, 1'b0);
		send_beat(8'hFF, 1'b1);
		send_text("HACKrootAdMiN", 1'b1);

		// saturation of length, upper-case and hack counters and of the score
		wait_idle();
		set_config(16'd63, 16'd63, 16'hFFFF, 16'd100, 1'b1);
		for (int i = 0; i < 770; i++)
			send_beat("!", 1'b0);
		for (int i = 0; i < 257; i++)
			send_text("HACK", 1'b0);
		send_beat("?", 1'b1);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: set_config(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
				1: set_config(16'hFFFF, 16'd63, 16'hFFFF, 16'd0, 1'b1);
				2: begin
					len = $urandom_range(10, 60);
					set_config(16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)),
						16'(len), 16'(len + $urandom_range(1, 100)), 1'b0);
				end
				RANDOM_PHASES - 1: set_config(16'd2, 16'd15, 16'd50, 16'd20, 1'b0);
				default: begin
					if ($urandom_range(0, 3) == 0)
						set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
							16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
							1'b1);
					else
						set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
							16'($urandom_range(0, 400)), 16'($urandom_range(0, 200)), 1'b0);
				end
			endcase
			if (phase == RANDOM_PHASES - 1) begin
				idle_pct = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 8;
					default: idle_pct = 30;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 8;
					default: stall_pct = 30;
				endcase
			end
			sent = 0;
			while (sent < PHASE_BYTES) begin
				len = ($urandom_range(0, 39) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
				build_message(len);
				sent += len;
				send_msg();
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_total == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/mkrs_pkg.sv
src/mkrs_count.sv
src/mkrs_score.sv
src/message_keyword_risk_scanner.sv
dv/risk_report_checker.sv
dv/tb_message_keyword_risk_scanner.sv
